// ===== rtl/sha256md_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256md_pkg
// Shared types, round constants, initial hash and round functions for the
// SHA-256 message digest block.
// ----------------------------------------------------------------------------
package sha256md_pkg;

  localparam int unsigned BLOCK_BITS = 512;
  localparam int unsigned DIGEST_BITS = 256;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Control from the byte sequencer to the compression core.
  typedef struct packed {
    logic start;
    logic init;
  } sha_ctrl_t;

  typedef struct packed {
    logic busy;
  } sha_stat_t;

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// ===== rtl/sha256md_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256md_core
// Compression core: one shared round datapath iterated over 64 rounds with a
// 16-word sliding message schedule, followed by the hash update in C_FINAL.
// ----------------------------------------------------------------------------
module sha256md_core
  import sha256md_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  sha_ctrl_t              ctrl,
  input  logic [BLOCK_BITS-1:0]  block,
  output sha_stat_t              stat,
  output logic [DIGEST_BITS-1:0] digest
);

  localparam logic [1:0] C_IDLE  = 2'd0;
  localparam logic [1:0] C_RUN   = 2'd1;
  localparam logic [1:0] C_FINAL = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [5:0]  round_r, round_nxt;
  logic [31:0] hash_r [0:7];
  logic [31:0] work_r [0:7];
  logic [31:0] w_r    [0:15];
  logic [31:0] t1, t2, w_new;

  always_comb begin
    t1 = work_r[7] + big_sig1(work_r[4]) +
         ((work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6])) +
         ROUND_K[round_r] + w_r[0];
    t2 = big_sig0(work_r[0]) +
         ((work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]));
    w_new = small_sig1(w_r[14]) + w_r[9] + small_sig0(w_r[1]) + w_r[0];
  end

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    case (state_r)
      C_IDLE: begin
        if (ctrl.start) begin
          state_nxt = C_RUN;
          round_nxt = 6'd0;
        end
      end
      C_RUN: begin
        round_nxt = round_r + 6'd1;
        if (round_r == 6'd63) begin
          state_nxt = C_FINAL;
        end
      end
      C_FINAL: begin
        state_nxt = C_IDLE;
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      round_r <= 6'd0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
    end
  end

  // Hash words are control-like: reset and init return them to the IV.
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.init) begin
      for (int i = 0; i < 8; i++) hash_r[i] <= INIT_HASH[i];
    end else if (state_r == C_FINAL) begin
      for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + work_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == C_IDLE && ctrl.start) begin
      for (int i = 0; i < 8; i++) work_r[i] <= hash_r[i];
      for (int i = 0; i < 16; i++) w_r[i] <= block[BLOCK_BITS-1-32*i -: 32];
    end else if (state_r == C_RUN) begin
      work_r[0] <= t1 + t2;
      work_r[1] <= work_r[0];
      work_r[2] <= work_r[1];
      work_r[3] <= work_r[2];
      work_r[4] <= work_r[3] + t1;
      work_r[5] <= work_r[4];
      work_r[6] <= work_r[5];
      work_r[7] <= work_r[6];
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
    end
  end

  assign stat.busy = (state_r != C_IDLE);

  always_comb begin
    for (int i = 0; i < 8; i++) digest[DIGEST_BITS-1-32*i -: 32] = hash_r[i];
  end

endmodule

// ===== rtl/sha256_message_digest.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_message_digest
// SHA-256 digest of a byte stream: gathers bytes into 64-byte blocks, pads the
// message at its end and returns the digest as four 64-bit beats.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  in_      input      one optional message byte and an end-of-message flag
//  out_     output     64 digest bits per beat, four beats per message
//
// A byte beat that neither completes a block nor ends the message leaves the
// input open to further beats. A beat that completes a block holds the input
// through the rounds of the shared round datapath, the hash update and the
// hand back to the input. At the end of a message the sequencer writes the pad
// bytes one per cycle up to the end of the block (and a second block when fewer
// than 9 bytes are free), compresses each block, then presents the four digest
// beats. Reset is synchronous and returns the block to the initial hash. A
// stalled output beat holds the whole block.

module sha256_message_digest
  import sha256md_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_word,
  output logic        out_last_word
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PAD  = 2'd1;
  localparam logic [1:0] S_BUSY = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [5:0]            pos_r, pos_nxt;
  logic [63:0]           bitcnt_r, bitcnt_nxt;
  logic [BLOCK_BITS-1:0] buf_r, buf_nxt;
  logic                  pad_pend_r, pad_pend_nxt;
  logic                  final_r, final_nxt;
  logic                  first_r, first_nxt;
  logic                  two_blk_r, two_blk_nxt;
  logic [1:0]            oidx_r, oidx_nxt;

  logic                  in_acc, out_acc, shift_en;
  logic [7:0]            byte_in, len_byte;
  logic [5:0]            pos_after;
  sha_ctrl_t             ctrl;
  sha_stat_t             stat;
  logic [DIGEST_BITS-1:0] digest;

  sha256md_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .block  (buf_nxt),
    .stat   (stat),
    .digest (digest)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  // Length bytes go out most significant first at block positions 56 to 63.
  assign len_byte = bitcnt_r[{3'(~pos_r[2:0]), 3'b000} +: 8];

  always_comb begin
    if (state_r == S_PAD) begin
      if (first_r) begin
        byte_in = PAD_BYTE;
      end else if (!two_blk_r && pos_r[5:3] == 3'b111) begin
        byte_in = len_byte;
      end else begin
        byte_in = 8'h00;
      end
    end else begin
      byte_in = in_data_byte;
    end
  end

  assign shift_en  = (in_acc && in_has_byte) || (state_r == S_PAD);
  assign buf_nxt   = shift_en ? {buf_r[BLOCK_BITS-9:0], byte_in} : buf_r;
  assign pos_after = in_has_byte ? pos_r + 6'd1 : pos_r;

  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    bitcnt_nxt   = bitcnt_r;
    pad_pend_nxt = pad_pend_r;
    final_nxt    = final_r;
    first_nxt    = first_r;
    two_blk_nxt  = two_blk_r;
    oidx_nxt     = oidx_r;
    ctrl.start   = 1'b0;
    ctrl.init    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_has_byte) begin
            pos_nxt    = pos_r + 6'd1;
            bitcnt_nxt = bitcnt_r + 64'd8;
            ctrl.start = (pos_r == 6'd63);
          end
          pad_pend_nxt = in_end_of_message;
          final_nxt    = 1'b0;
          if (in_end_of_message) begin
            first_nxt   = 1'b1;
            two_blk_nxt = (pos_after[5:3] == 3'b111);
          end
          if (in_has_byte && pos_r == 6'd63) begin
            state_nxt = S_BUSY;
          end else if (in_end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        pos_nxt   = pos_r + 6'd1;
        first_nxt = 1'b0;
        if (pos_r == 6'd63) begin
          ctrl.start   = 1'b1;
          final_nxt    = !two_blk_r;
          pad_pend_nxt = two_blk_r;
          two_blk_nxt  = 1'b0;
          state_nxt    = S_BUSY;
        end
      end
      S_BUSY: begin
        if (!stat.busy) begin
          if (final_r) begin
            state_nxt = S_OUT;
            oidx_nxt  = 2'd0;
          end else if (pad_pend_r) begin
            state_nxt = S_PAD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (out_acc) begin
          oidx_nxt = oidx_r + 2'd1;
          if (oidx_r == 2'd3) begin
            ctrl.init    = 1'b1;
            pos_nxt      = 6'd0;
            bitcnt_nxt   = 64'd0;
            final_nxt    = 1'b0;
            pad_pend_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pos_r      <= 6'd0;
      bitcnt_r   <= 64'd0;
      pad_pend_r <= 1'b0;
      final_r    <= 1'b0;
      first_r    <= 1'b0;
      two_blk_r  <= 1'b0;
      oidx_r     <= 2'd0;
    end else begin
      state_r    <= state_nxt;
      pos_r      <= pos_nxt;
      bitcnt_r   <= bitcnt_nxt;
      pad_pend_r <= pad_pend_nxt;
      final_r    <= final_nxt;
      first_r    <= first_nxt;
      two_blk_r  <= two_blk_nxt;
      oidx_r     <= oidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  always_comb begin
    case (oidx_r)
      2'd0:    out_digest_word = digest[255:192];
      2'd1:    out_digest_word = digest[191:128];
      2'd2:    out_digest_word = digest[127:64];
      2'd3:    out_digest_word = digest[63:0];
      default: out_digest_word = digest[255:192];
    endcase
  end

  assign out_last_word = (oidx_r == 2'd3);

endmodule

// ===== rtl/sha256md_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256md_checker
// Port-level checks on the SHA-256 digest block, bound to the top level.
// ----------------------------------------------------------------------------
module sha256md_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_end_of_message,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_digest_word,
  input logic        out_last_word
);

  // A stalled digest beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_word) &&
    $stable(out_last_word))
    else $error("digest beat changed while stalled");

  // Input is never taken while digest beats are pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted during digest output");

  // The last beat closes the message's output.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_word |=> !out_valid)
    else $error("output continued after last beat");

  // A beat that does not end the message produces no output.
  a_mid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_end_of_message |=> !out_valid)
    else $error("output without end of message");

endmodule

bind sha256_message_digest sha256md_checker u_sha256md_checker (.*);
